>>> hw/rtl/nearest_neighbor_downscaler_top_macros.svh
// Assertion macros used by the downscaler checker.
`ifndef NEAREST_NEIGHBOR_DOWNSCALER_TOP_MACROS_SVH
`define NEAREST_NEIGHBOR_DOWNSCALER_TOP_MACROS_SVH

// Same-cycle implication.
`define NND_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nnd: same-cycle check failed");

// Next-cycle implication.
`define NND_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nnd: next-cycle check failed");

`endif

>>> hw/rtl/nnd_pkg.sv
// Shared widths, register indexes and divider types for the downscaler.
package nnd_pkg;

   localparam int DIM_W      = 13;
   localparam int PIX_W      = 8;
   localparam int POS_W      = 12;
   localparam int PROD_W     = 2 * DIM_W;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam int unsigned    DIM_LIMIT = (2 ** DIM_W) - 1;
   localparam logic [DIM_W-1:0] CFG_RESET = 13'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_WIDTH    = 4'd0,
      REG_FRAME_HEIGHT   = 4'd1,
      REG_MAX_OUT_WIDTH  = 4'd2,
      REG_MAX_OUT_HEIGHT = 4'd3
   } csr_reg_type;

   typedef struct packed {
      logic              start;
      logic [PROD_W-1:0] dividend;
      logic [DIM_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [PROD_W-1:0] quotient;
      logic [DIM_W-1:0]  remainder;
   } div_rsp_type;

endpackage

>>> hw/rtl/nnd_if.sv
// Channel interfaces: source pixels, result pixels and register writes.
interface nnd_req_if import nnd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] red;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

interface nnd_rsp_if import nnd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] out_red;
   logic [PIX_W-1:0] out_green;
   logic [PIX_W-1:0] out_blue;
   logic [POS_W-1:0] out_col;
   logic [POS_W-1:0] out_row;
   logic [DIM_W-1:0] scaled_width;
   logic [DIM_W-1:0] scaled_height;
   logic             frame_last;

   modport source (output valid, out_red, out_green, out_blue, out_col, out_row,
                   scaled_width, scaled_height, frame_last, input ready);
   modport sink   (input valid, out_red, out_green, out_blue, out_col, out_row,
                   scaled_width, scaled_height, frame_last, output ready);
endinterface

interface nnd_csr_if import nnd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/nnd_divider.sv
// Shared restoring divider, one quotient bit per cycle.
module nnd_divider import nnd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(PROD_W);

   logic [PROD_W-1:0] dq_ff, dq_in;
   logic [DIM_W-1:0]  rem_ff, rem_in;
   logic [DIM_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIM_W:0]    shifted;
   logic [DIM_W:0]    diff;
   logic              ge;

   assign shifted = {rem_ff, dq_ff[PROD_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign ge      = shifted >= {1'b0, dvs_ff};

   always_comb begin
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         dq_in   = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIM_W-1:0] : shifted[DIM_W-1:0];
         dq_in  = {dq_ff[PROD_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(PROD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = dq_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

>>> hw/rtl/nearest_neighbor_downscaler_top.sv
// Nearest-neighbour downscaler: sequencer, step tracking and output register.
//
// Source pixels arrive in raster order on req_bus, one transaction per pixel.
// Each accepted pixel gives zero or one transaction on rsp_bus, carrying the
// pixel, its output column and row, the output frame size and a last flag.
// Registers are written on csr_bus (always ready); they are latched at the
// first pixel of each frame, so they should be written between frames.
// An ordinary pixel is accepted in the idle state and then passes to the step
// state, in which the column and row trackers are compared and advanced.
// The first pixel of a frame also runs the size setup through one shared
// multiplier and one shared serial divider: two products, then two or three
// 26-step divisions, before it reaches the step state.
// req_bus.ready is high only while the sequencer is idle.
// Results wait in an output register; if it is still full when the step
// cycle wants it, the step holds until rsp_bus takes the pending result.
// Reset (synchronous) restores register defaults of 256 and starts a new frame.
module nearest_neighbor_downscaler_top import nnd_pkg::*; #(
   parameter int unsigned MAX_DIM = 4096
) (
   input logic        clock,
   input logic        reset,
   nnd_csr_if.sink    csr_bus,
   nnd_req_if.sink    req_bus,
   nnd_rsp_if.source  rsp_bus
);

   localparam int unsigned      CLAMP_MAX = (MAX_DIM > DIM_LIMIT) ? DIM_LIMIT : MAX_DIM;
   localparam logic [DIM_W-1:0] CLAMP_VAL = DIM_W'(CLAMP_MAX);

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_MUL_A,
      S_MUL_B,
      S_DECIDE,
      S_DIV_SIDE,
      S_DIV_COL,
      S_DIV_ROW,
      S_STEP
   } state_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > CLAMP_VAL) begin
         r = CLAMP_VAL;
      end else begin
         r = v;
      end
      return r;
   endfunction

   state_type         state_ff, state_in;
   logic [DIM_W-1:0]  cfg_fw_ff, cfg_fw_in, cfg_fh_ff, cfg_fh_in;
   logic [DIM_W-1:0]  cfg_mw_ff, cfg_mw_in, cfg_mh_ff, cfg_mh_in;
   logic [PIX_W-1:0]  pix_r_ff, pix_r_in, pix_g_ff, pix_g_in, pix_b_ff, pix_b_in;
   logic [DIM_W-1:0]  lat_w_ff, lat_w_in, lat_h_ff, lat_h_in;
   logic [DIM_W-1:0]  lim_w_ff, lim_w_in, lim_h_ff, lim_h_in;
   logic [PROD_W-1:0] prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic              wlim_ff, wlim_in;
   logic [DIM_W-1:0]  dst_w_ff, dst_w_in, dst_h_ff, dst_h_in;
   logic [DIM_W-1:0]  step_q_ff [4];
   logic [DIM_W-1:0]  step_q_in [4];
   logic [DIM_W-1:0]  src_col_ff, src_col_in, src_row_ff, src_row_in;
   logic [DIM_W-1:0]  dst_col_ff, dst_col_in, dst_row_ff, dst_row_in;
   logic [DIM_W-1:0]  want_col_ff, want_col_in, want_row_ff, want_row_in;
   logic [DIM_W-1:0]  col_frac_ff, col_frac_in, row_frac_ff, row_frac_in;
   div_req_type       div_req_ff, div_req_in;
   div_rsp_type       div_rsp;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  o_r_ff, o_r_in, o_g_ff, o_g_in, o_b_ff, o_b_in;
   logic [POS_W-1:0]  o_col_ff, o_col_in, o_row_ff, o_row_in;
   logic [DIM_W-1:0]  o_sw_ff, o_sw_in, o_sh_ff, o_sh_in;
   logic              o_last_ff, o_last_in;

   logic [DIM_W-1:0]  mul_x, mul_y;
   logic [PROD_W-1:0] mul_p;
   logic [DIM_W-1:0]  side;
   logic              hit, out_free;
   logic [DIM_W-1:0]  dst_col_inc, dst_row_inc, src_col_inc, src_row_inc;
   logic [DIM_W:0]    col_sum, row_sum;
   logic              col_wrap, row_wrap;

   nnd_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   assign mul_x = (state_ff == S_MUL_A) ? lim_w_ff : lim_h_ff;
   assign mul_y = (state_ff == S_MUL_A) ? lat_h_ff : lat_w_ff;
   assign mul_p = PROD_W'(mul_x) * PROD_W'(mul_y);

   assign side = (div_rsp.quotient == '0) ? DIM_W'(1) : div_rsp.quotient[DIM_W-1:0];

   assign hit = (dst_row_ff < dst_h_ff) && (dst_col_ff < dst_w_ff) &&
                (src_row_ff == want_row_ff) && (src_col_ff == want_col_ff);
   assign out_free    = !rsp_valid_ff || rsp_bus.ready;
   assign dst_col_inc = dst_col_ff + DIM_W'(1);
   assign dst_row_inc = dst_row_ff + DIM_W'(1);
   assign src_col_inc = src_col_ff + DIM_W'(1);
   assign src_row_inc = src_row_ff + DIM_W'(1);
   assign col_sum     = {1'b0, col_frac_ff} + {1'b0, step_q_ff[1]};
   assign row_sum     = {1'b0, row_frac_ff} + {1'b0, step_q_ff[3]};
   assign col_wrap    = col_sum >= {1'b0, dst_w_ff};
   assign row_wrap    = row_sum >= {1'b0, dst_h_ff};

   always_comb begin
      cfg_fw_in = cfg_fw_ff;
      cfg_fh_in = cfg_fh_ff;
      cfg_mw_in = cfg_mw_ff;
      cfg_mh_in = cfg_mh_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_FRAME_WIDTH:    cfg_fw_in = csr_bus.data[DIM_W-1:0];
            REG_FRAME_HEIGHT:   cfg_fh_in = csr_bus.data[DIM_W-1:0];
            REG_MAX_OUT_WIDTH:  cfg_mw_in = csr_bus.data[DIM_W-1:0];
            REG_MAX_OUT_HEIGHT: cfg_mh_in = csr_bus.data[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      pix_r_in     = pix_r_ff;
      pix_g_in     = pix_g_ff;
      pix_b_in     = pix_b_ff;
      lat_w_in     = lat_w_ff;
      lat_h_in     = lat_h_ff;
      lim_w_in     = lim_w_ff;
      lim_h_in     = lim_h_ff;
      prod_a_in    = prod_a_ff;
      prod_b_in    = prod_b_ff;
      wlim_in      = wlim_ff;
      dst_w_in     = dst_w_ff;
      dst_h_in     = dst_h_ff;
      step_q_in    = step_q_ff;
      src_col_in   = src_col_ff;
      src_row_in   = src_row_ff;
      dst_col_in   = dst_col_ff;
      dst_row_in   = dst_row_ff;
      want_col_in  = want_col_ff;
      want_row_in  = want_row_ff;
      col_frac_in  = col_frac_ff;
      row_frac_in  = row_frac_ff;
      div_req_in   = div_req_ff;
      div_req_in.start = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      o_r_in       = o_r_ff;
      o_g_in       = o_g_ff;
      o_b_in       = o_b_ff;
      o_col_in     = o_col_ff;
      o_row_in     = o_row_ff;
      o_sw_in      = o_sw_ff;
      o_sh_in      = o_sh_ff;
      o_last_in    = o_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               pix_r_in = req_bus.red;
               pix_g_in = req_bus.green;
               pix_b_in = req_bus.blue;
               state_in = (src_col_ff == '0 && src_row_ff == '0) ? S_START : S_STEP;
            end
         end
         S_START: begin
            lat_w_in = clamp_dim(cfg_fw_ff);
            lat_h_in = clamp_dim(cfg_fh_ff);
            lim_w_in = clamp_dim(cfg_mw_ff);
            lim_h_in = clamp_dim(cfg_mh_ff);
            state_in = S_MUL_A;
         end
         S_MUL_A: begin
            prod_a_in = mul_p;
            state_in  = S_MUL_B;
         end
         S_MUL_B: begin
            prod_b_in = mul_p;
            state_in  = S_DECIDE;
         end
         S_DECIDE: begin
            div_req_in.start = 1'b1;
            if (!(lat_w_ff > lim_w_ff || lat_h_ff > lim_h_ff)) begin
               dst_w_in            = lat_w_ff;
               dst_h_in            = lat_h_ff;
               div_req_in.dividend = PROD_W'(lat_w_ff);
               div_req_in.divisor  = lat_w_ff;
               state_in            = S_DIV_COL;
            end else if (prod_a_ff <= prod_b_ff) begin
               wlim_in             = 1'b1;
               dst_w_in            = lim_w_ff;
               div_req_in.dividend = prod_a_ff;
               div_req_in.divisor  = lat_w_ff;
               state_in            = S_DIV_SIDE;
            end else begin
               wlim_in             = 1'b0;
               dst_h_in            = lim_h_ff;
               div_req_in.dividend = prod_b_ff;
               div_req_in.divisor  = lat_h_ff;
               state_in            = S_DIV_SIDE;
            end
         end
         S_DIV_SIDE: begin
            if (div_rsp.done) begin
               div_req_in.start    = 1'b1;
               div_req_in.dividend = PROD_W'(lat_w_ff);
               if (wlim_ff) begin
                  dst_h_in           = side;
                  div_req_in.divisor = dst_w_ff;
               end else begin
                  dst_w_in           = side;
                  div_req_in.divisor = side;
               end
               state_in = S_DIV_COL;
            end
         end
         S_DIV_COL: begin
            if (div_rsp.done) begin
               step_q_in[0]        = div_rsp.quotient[DIM_W-1:0];
               step_q_in[1]        = div_rsp.remainder;
               div_req_in.start    = 1'b1;
               div_req_in.dividend = PROD_W'(lat_h_ff);
               div_req_in.divisor  = dst_h_ff;
               state_in            = S_DIV_ROW;
            end
         end
         S_DIV_ROW: begin
            if (div_rsp.done) begin
               step_q_in[2] = div_rsp.quotient[DIM_W-1:0];
               step_q_in[3] = div_rsp.remainder;
               dst_col_in   = '0;
               dst_row_in   = '0;
               want_col_in  = '0;
               want_row_in  = '0;
               col_frac_in  = '0;
               row_frac_in  = '0;
               state_in     = S_STEP;
            end
         end
         S_STEP: begin
            if (!hit || out_free) begin
               if (hit) begin
                  rsp_valid_in = 1'b1;
                  o_r_in       = pix_r_ff;
                  o_g_in       = pix_g_ff;
                  o_b_in       = pix_b_ff;
                  o_col_in     = POS_W'(dst_col_ff);
                  o_row_in     = POS_W'(dst_row_ff);
                  o_sw_in      = dst_w_ff;
                  o_sh_in      = dst_h_ff;
                  o_last_in    = (dst_col_inc == dst_w_ff) && (dst_row_inc == dst_h_ff);
                  if (dst_col_inc >= dst_w_ff) begin
                     dst_col_in  = '0;
                     want_col_in = '0;
                     col_frac_in = '0;
                     dst_row_in  = dst_row_inc;
                     want_row_in = want_row_ff + step_q_ff[2] + DIM_W'(row_wrap);
                     row_frac_in = row_wrap ? DIM_W'(row_sum - {1'b0, dst_h_ff})
                                            : DIM_W'(row_sum);
                  end else begin
                     dst_col_in  = dst_col_inc;
                     want_col_in = want_col_ff + step_q_ff[0] + DIM_W'(col_wrap);
                     col_frac_in = col_wrap ? DIM_W'(col_sum - {1'b0, dst_w_ff})
                                            : DIM_W'(col_sum);
                  end
               end
               if (src_col_inc >= lat_w_ff) begin
                  src_col_in = '0;
                  src_row_in = (src_row_inc >= lat_h_ff) ? '0 : src_row_inc;
               end else begin
                  src_col_in = src_col_inc;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      pix_r_ff    <= pix_r_in;
      pix_g_ff    <= pix_g_in;
      pix_b_ff    <= pix_b_in;
      lat_w_ff    <= lat_w_in;
      lat_h_ff    <= lat_h_in;
      lim_w_ff    <= lim_w_in;
      lim_h_ff    <= lim_h_in;
      prod_a_ff   <= prod_a_in;
      prod_b_ff   <= prod_b_in;
      wlim_ff     <= wlim_in;
      dst_w_ff    <= dst_w_in;
      dst_h_ff    <= dst_h_in;
      step_q_ff   <= step_q_in;
      dst_col_ff  <= dst_col_in;
      dst_row_ff  <= dst_row_in;
      want_col_ff <= want_col_in;
      want_row_ff <= want_row_in;
      col_frac_ff <= col_frac_in;
      row_frac_ff <= row_frac_in;
      o_r_ff      <= o_r_in;
      o_g_ff      <= o_g_in;
      o_b_ff      <= o_b_in;
      o_col_ff    <= o_col_in;
      o_row_ff    <= o_row_in;
      o_sw_ff     <= o_sw_in;
      o_sh_ff     <= o_sh_in;
      o_last_ff   <= o_last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         src_col_ff   <= '0;
         src_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         div_req_ff   <= '0;
         cfg_fw_ff    <= CFG_RESET;
         cfg_fh_ff    <= CFG_RESET;
         cfg_mw_ff    <= CFG_RESET;
         cfg_mh_ff    <= CFG_RESET;
      end else begin
         state_ff     <= state_in;
         src_col_ff   <= src_col_in;
         src_row_ff   <= src_row_in;
         rsp_valid_ff <= rsp_valid_in;
         div_req_ff   <= div_req_in;
         cfg_fw_ff    <= cfg_fw_in;
         cfg_fh_ff    <= cfg_fh_in;
         cfg_mw_ff    <= cfg_mw_in;
         cfg_mh_ff    <= cfg_mh_in;
      end
   end

   assign csr_bus.ready         = 1'b1;
   assign req_bus.ready         = (state_ff == S_IDLE);
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.out_red       = o_r_ff;
   assign rsp_bus.out_green     = o_g_ff;
   assign rsp_bus.out_blue      = o_b_ff;
   assign rsp_bus.out_col       = o_col_ff;
   assign rsp_bus.out_row       = o_row_ff;
   assign rsp_bus.scaled_width  = o_sw_ff;
   assign rsp_bus.scaled_height = o_sh_ff;
   assign rsp_bus.frame_last    = o_last_ff;

endmodule

>>> hw/rtl/nnd_checker.sv
// Port-level checks for the downscaler, bound to the top level.
`include "nearest_neighbor_downscaler_top_macros.svh"

module nnd_checker import nnd_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [POS_W-1:0] out_col,
   input logic [POS_W-1:0] out_row,
   input logic [DIM_W-1:0] scaled_width,
   input logic [DIM_W-1:0] scaled_height,
   input logic             frame_last
);

   // one transaction at a time: the sequencer drops ready after taking a pixel
   `NND_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   `NND_ASSERT_IMPL(a_pos_in_frame, clock, reset, rsp_valid, ({1'b0, out_col} < scaled_width) && ({1'b0, out_row} < scaled_height))

   `NND_ASSERT_IMPL(a_last_at_corner, clock, reset, rsp_valid && frame_last, (out_col == POS_W'(scaled_width - 1'b1)) && (out_row == POS_W'(scaled_height - 1'b1)))

   `NND_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(out_col) && $stable(out_row))

endmodule

bind nearest_neighbor_downscaler_top nnd_checker u_nnd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .out_col       (rsp_bus.out_col),
   .out_row       (rsp_bus.out_row),
   .scaled_width  (rsp_bus.scaled_width),
   .scaled_height (rsp_bus.scaled_height),
   .frame_last    (rsp_bus.frame_last)
);

>>> dv/tb_nearest_neighbor_downscaler_top.sv
// Self-checking testbench for nearest_neighbor_downscaler_top against a scaling predictor.
module tb_nearest_neighbor_downscaler_top import nnd_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned DIM_MAX       = 4096;
   localparam int unsigned SETTLE_CYCLES = 200;
   localparam int unsigned HOLD_CYCLES   = 600;
   localparam int unsigned CYCLE_LIMIT   = 3_000_000;
   localparam int unsigned RANDOM_ITEMS  = 180;
   localparam int unsigned TALL_ITEMS    = 48;
   localparam int unsigned REPORT_LIMIT  = 10;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 4'd9;

   typedef logic [DIM_W:0]    track_type;
   typedef logic [PROD_W-1:0] wide_type;
   typedef int unsigned       count_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic [POS_W-1:0] col;
      logic [POS_W-1:0] row;
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic             last;
   } scaled_pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   nnd_csr_if csr_bus ();
   nnd_req_if req_bus ();
   nnd_rsp_if rsp_bus ();

   nearest_neighbor_downscaler_top #(.MAX_DIM(DIM_MAX)) u_top (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   rgb_type          source_pixels[$];
   scaled_pixel_type scaled_pixels[$];
   int unsigned   mismatches = 0;
   int unsigned   cycles = 0;
   int unsigned   send_idle_pct = 17;
   int unsigned   recv_idle_pct = 76;
   int unsigned   hold_left = 0;
   logic          req_taken = 1'b0;
   logic          hold_arm = 1'b0;
   logic          hold_done = 1'b0;

   // scaler state, latched sizes and step trackers
   logic [DIM_W-1:0] cfg_frame_w = CFG_RESET;
   logic [DIM_W-1:0] cfg_frame_h = CFG_RESET;
   logic [DIM_W-1:0] cfg_max_w = CFG_RESET;
   logic [DIM_W-1:0] cfg_max_h = CFG_RESET;
   track_type src_x = '0, src_y = '0, held_w = '0, held_h = '0;
   track_type out_w = '0, out_h = '0, out_x = '0, out_y = '0;
   track_type next_x = '0, x_frac = '0, next_y = '0, y_frac = '0;
   track_type x_step = '0, x_rem = '0, y_step = '0, y_rem = '0;

   function automatic track_type dim_clamp(input logic [DIM_W-1:0] v);
      if (v == '0) return track_type'(1);
      if (v > DIM_MAX) return track_type'(DIM_MAX);
      return track_type'(v);
   endfunction

   task automatic latch_frame_size();
      wide_type w, h, mw, mh, ow, oh;
      w  = wide_type'(dim_clamp(cfg_frame_w));
      h  = wide_type'(dim_clamp(cfg_frame_h));
      mw = wide_type'(dim_clamp(cfg_max_w));
      mh = wide_type'(dim_clamp(cfg_max_h));
      ow = w;
      oh = h;
      if (w > mw || h > mh) begin
         // width wins a tie
         if (mw * h <= mh * w) begin
            ow = mw;
            oh = h * mw / w;
         end else begin
            oh = mh;
            ow = w * mh / h;
         end
         if (ow == '0) ow = wide_type'(1);
         if (oh == '0) oh = wide_type'(1);
      end
      held_w = track_type'(w);
      held_h = track_type'(h);
      out_w  = track_type'(ow);
      out_h  = track_type'(oh);
      x_step = track_type'(w / ow);
      x_rem  = track_type'(w % ow);
      y_step = track_type'(h / oh);
      y_rem  = track_type'(h % oh);
      out_x  = '0;
      out_y  = '0;
      next_x = '0;
      x_frac = '0;
      next_y = '0;
      y_frac = '0;
   endtask

   task automatic scale_pixel(input rgb_type px);
      scaled_pixel_type r;
      if (src_x == '0 && src_y == '0) latch_frame_size();
      if (out_y < out_h && out_x < out_w && src_y == next_y && src_x == next_x) begin
         r.red    = px.red;
         r.green  = px.green;
         r.blue   = px.blue;
         r.col    = out_x[POS_W-1:0];
         r.row    = out_y[POS_W-1:0];
         r.width  = out_w[DIM_W-1:0];
         r.height = out_h[DIM_W-1:0];
         r.last   = (out_x + 1'b1 == out_w) && (out_y + 1'b1 == out_h);
         scaled_pixels = {scaled_pixels, r};
         out_x  = out_x + 1'b1;
         next_x = next_x + x_step;
         x_frac = x_frac + x_rem;
         if (x_frac >= out_w) begin
            x_frac = x_frac - out_w;
            next_x = next_x + 1'b1;
         end
         if (out_x >= out_w) begin
            out_x  = '0;
            next_x = '0;
            x_frac = '0;
            out_y  = out_y + 1'b1;
            next_y = next_y + y_step;
            y_frac = y_frac + y_rem;
            if (y_frac >= out_h) begin
               y_frac = y_frac - out_h;
               next_y = next_y + 1'b1;
            end
         end
      end
      src_x = src_x + 1'b1;
      if (src_x >= held_w) begin
         src_x = '0;
         src_y = src_y + 1'b1;
         if (src_y >= held_h) src_y = '0;
      end
   endtask

   function automatic int unsigned full_frame();
      return count_type'(dim_clamp(cfg_frame_w)) * count_type'(dim_clamp(cfg_frame_h));
   endfunction

   function automatic int unsigned frame_pixels_left();
      if (src_x == '0 && src_y == '0) return full_frame();
      return count_type'(held_w) * count_type'(held_h)
             - (count_type'(src_y) * count_type'(held_w) + count_type'(src_x));
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_frame_dim();
      logic [CSR_DATA_W-1:0] v;
      v = CSR_DATA_W'($urandom_range(12, 1));
      if ($urandom_range(19) == 0) v = '0;
      v[CSR_DATA_W-1:DIM_W] = (CSR_DATA_W-DIM_W)'($urandom);
      return v;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] rand_limit_dim();
      logic [CSR_DATA_W-1:0] v;
      case ($urandom_range(9))
         0: v = '0;
         1: v = CSR_DATA_W'($urandom_range(8191, 4097));
         2: v = CSR_DATA_W'(DIM_MAX);
         default: v = CSR_DATA_W'($urandom_range(12, 1));
      endcase
      v[CSR_DATA_W-1:DIM_W] = (CSR_DATA_W-DIM_W)'($urandom);
      return v;
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("%s mismatch: expected %0d, got %0d", name, want, got);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic load_sizes(input logic [CSR_DATA_W-1:0] fw, input logic [CSR_DATA_W-1:0] fh,
                             input logic [CSR_DATA_W-1:0] mw, input logic [CSR_DATA_W-1:0] mh);
      write_reg(REG_FRAME_WIDTH, fw);
      write_reg(REG_FRAME_HEIGHT, fh);
      write_reg(REG_MAX_OUT_WIDTH, mw);
      write_reg(REG_MAX_OUT_HEIGHT, mh);
   endtask

   task automatic push_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                             input logic [PIX_W-1:0] b);
      rgb_type px;
      px.red   = r;
      px.green = g;
      px.blue  = b;
      source_pixels = {source_pixels, px};
   endtask

   task automatic queue_random(input int unsigned n);
      for (int unsigned i = 0; i < n; i++)
         push_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
   endtask

   // idle only once every transaction is through and any frame setup has finished
   task automatic wait_drained();
      do @(negedge clock); while (source_pixels.size() != 0 || scaled_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin
      rgb_type          seen;
      scaled_pixel_type want;
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               REG_FRAME_WIDTH: begin
                  cfg_frame_w = csr_bus.data[DIM_W-1:0];
               end
               REG_FRAME_HEIGHT: begin
                  cfg_frame_h = csr_bus.data[DIM_W-1:0];
               end
               REG_MAX_OUT_WIDTH: begin
                  cfg_max_w = csr_bus.data[DIM_W-1:0];
               end
               REG_MAX_OUT_HEIGHT: begin
                  cfg_max_h = csr_bus.data[DIM_W-1:0];
               end
               default: ;
            endcase
         end
         req_taken <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            seen.red   = req_bus.red;
            seen.green = req_bus.green;
            seen.blue  = req_bus.blue;
            void'(source_pixels.pop_front());
            scale_pixel(seen);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (scaled_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("unexpected transaction: col %0d row %0d",
                           rsp_bus.out_col, rsp_bus.out_row);
            end else begin
               want = scaled_pixels.pop_front();
               check_field("out_red", want.red, rsp_bus.out_red);
               check_field("out_green", want.green, rsp_bus.out_green);
               check_field("out_blue", want.blue, rsp_bus.out_blue);
               check_field("out_col", want.col, rsp_bus.out_col);
               check_field("out_row", want.row, rsp_bus.out_row);
               check_field("scaled_width", want.width, rsp_bus.scaled_width);
               check_field("scaled_height", want.height, rsp_bus.scaled_height);
               check_field("frame_last", want.last, rsp_bus.frame_last);
            end
         end
      end
   end

   always @(negedge clock) begin
      if (!(req_bus.valid && !req_taken)) begin
         if (source_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_bus.valid <= 1'b1;
            req_bus.red   <= source_pixels[0].red;
            req_bus.green <= source_pixels[0].green;
            req_bus.blue  <= source_pixels[0].blue;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
   end

   // one long back-pressure stretch on the result side
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_arm && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("nearest_neighbor_downscaler_top verification failed");
         $finish;
      end
   end

   initial begin
      int unsigned pushed;
      int unsigned count;
      req_bus.valid = 1'b0;
      req_bus.red   = '0;
      req_bus.green = '0;
      req_bus.blue  = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fits unchanged; limit above the maximum and upper data bits set
      load_sizes(16'd3, 16'd2, 16'hFFFF, 16'd4096);
      push_pixel(8'h00, 8'h00, 8'h00);
      push_pixel(8'hFF, 8'hFF, 8'hFF);
      push_pixel(8'hAA, 8'h55, 8'hF0);
      push_pixel(8'h55, 8'hAA, 8'h0F);
      push_pixel(8'hFF, 8'h00, 8'h80);
      push_pixel(8'h01, 8'hFE, 8'h7F);
      wait_drained();
      // zero limits count as one, sides tie
      load_sizes(16'd2, 16'd2, 16'd0, 16'd0);
      queue_random(4);
      wait_drained();
      // height limits, width floors to zero and becomes one
      load_sizes(16'd2, 16'd5, 16'd4, 16'd2);
      queue_random(10);
      wait_drained();
      // write in the middle of a frame only applies from the next one
      load_sizes(16'd1, 16'd2, 16'd1, 16'd1);
      queue_random(1);
      wait_drained();
      write_reg(REG_FRAME_HEIGHT, 16'd3);
      write_reg(REG_SPARE, 16'd5);
      queue_random(frame_pixels_left());
      wait_drained();

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 17;
               recv_idle_pct = 76;
            end
            1: begin
               send_idle_pct = 76;
               recv_idle_pct = 17;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (phase == 2) hold_arm = 1'b1;
         pushed = 0;
         while (pushed < RANDOM_ITEMS) begin
            load_sizes(rand_frame_dim(), rand_frame_dim(), rand_limit_dim(), rand_limit_dim());
            count = frame_pixels_left() + $urandom_range(2) * full_frame();
            if (count > 1 && $urandom_range(4) == 0) count = $urandom_range(count - 1, 1);
            queue_random(count);
            pushed += count;
            wait_drained();
         end
      end

      // frame taller than the maximum, only its first rows are sent
      load_sizes(16'd1, 16'h1FFF, 16'd0, 16'd4096);
      count = TALL_ITEMS;
      if (src_x != '0 || src_y != '0) count += frame_pixels_left();
      queue_random(count);
      wait_drained();

      if (mismatches == 0) begin
         $display("nearest_neighbor_downscaler_top verification clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("nearest_neighbor_downscaler_top verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/nnd_pkg.sv
hw/rtl/nnd_if.sv
hw/rtl/nnd_divider.sv
hw/rtl/nearest_neighbor_downscaler_top.sv
hw/rtl/nnd_checker.sv
dv/tb_nearest_neighbor_downscaler_top.sv
